// ===== hw/rtl/dsq_pkg.sv =====
// ----------------------------------------------------------------------------
// dsq_pkg
// Shared types, field positions and codes of the four-channel DMA sequencer.
// ----------------------------------------------------------------------------
package dsq_pkg;

	localparam int NUM_CH = 4;
	localparam int CH_W   = 2;
	localparam int CNT_W  = 17;
	localparam int CTL_W  = 26;
	localparam int ADR_W  = 56;
	localparam int OUT_AW = 28;

	// control register fields
	localparam int CTL_EN     = 16;
	localparam int CTL_TIM_LO = 17;
	localparam int CTL_SRC_LO = 19;
	localparam int CTL_DST_LO = 21;
	localparam int CTL_WORD   = 23;
	localparam int CTL_REPEAT = 24;
	localparam int CTL_IRQ    = 25;

	// register index of the first control register
	localparam logic [2:0] REG_CTRL0 = 3'd4;

	localparam logic CMD_TRIGGER = 1'b0;
	localparam logic CMD_ADVANCE = 1'b1;

	localparam logic [1:0] TIM_NOW     = 2'd0;
	localparam logic [1:0] TIM_VBLANK  = 2'd1;
	localparam logic [1:0] TIM_HBLANK  = 2'd2;
	localparam logic [1:0] TIM_SPECIAL = 2'd3;

	localparam logic [1:0] AM_INC    = 2'd0;
	localparam logic [1:0] AM_DEC    = 2'd1;
	localparam logic [1:0] AM_FIXED  = 2'd2;
	localparam logic [1:0] AM_RELOAD = 2'd3;

	localparam logic [5:0]       FIFO_THRESHOLD = 6'd16;
	localparam logic [CNT_W-1:0] FORCED_COUNT   = 17'd4;

	typedef struct packed {
		logic last;
		logic irq;
		logic word;
		logic live_clr;
	} step_t;

	function automatic logic [CNT_W-1:0] full_count(input logic [15:0] cnt);
		full_count = (cnt == 16'd0) ? 17'h10000 : {1'b0, cnt};
	endfunction

endpackage

// ===== hw/rtl/dsq_ram.sv =====
// ----------------------------------------------------------------------------
// dsq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dsq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== hw/rtl/dsq_step.sv =====
// ----------------------------------------------------------------------------
// dsq_step
// Issue step for one channel: address stepping, count decrement and reload.
// ----------------------------------------------------------------------------
module dsq_step #(
	parameter int ADDR_BITS = 28
) (
	input  logic [2*ADDR_BITS+dsq_pkg::CNT_W-1:0] rd_data,
	input  logic                                  count4,
	input  logic [dsq_pkg::CTL_W-1:0]             ctrl,
	input  logic                                  forced,
	input  logic [ADDR_BITS-1:0]                  reload_tgt,
	output logic [ADDR_BITS-1:0]                  cur_src,
	output logic [ADDR_BITS-1:0]                  cur_tgt,
	output logic [2*ADDR_BITS+dsq_pkg::CNT_W-1:0] wr_data,
	output dsq_pkg::step_t                        st
);
	import dsq_pkg::*;

	logic [CNT_W-1:0]     cnt;
	logic [CNT_W-1:0]     cnt_n;
	logic [ADDR_BITS-1:0] seek;
	logic [ADDR_BITS-1:0] src_n;
	logic [ADDR_BITS-1:0] tgt_n;
	logic [1:0]           smode;
	logic [1:0]           tmode;

	always_comb begin
		cur_src  = rd_data[ADDR_BITS-1:0];
		cur_tgt  = rd_data[2*ADDR_BITS-1:ADDR_BITS];
		cnt      = count4 ? FORCED_COUNT : rd_data[2*ADDR_BITS +: CNT_W];
		st.word  = forced | ctrl[CTL_WORD];
		seek     = st.word ? ADDR_BITS'(4) : ADDR_BITS'(2);
		smode    = ctrl[CTL_SRC_LO +: 2];
		tmode    = forced ? AM_FIXED : ctrl[CTL_DST_LO +: 2];

		unique case (smode)
			AM_INC:  src_n = cur_src + seek;
			AM_DEC:  src_n = cur_src - seek;
			default: src_n = cur_src;
		endcase

		unique case (tmode)
			AM_INC, AM_RELOAD: tgt_n = cur_tgt + seek;
			AM_DEC:            tgt_n = cur_tgt - seek;
			default:           tgt_n = cur_tgt;
		endcase

		st.last     = (cnt <= CNT_W'(1));
		st.irq      = st.last & ctrl[CTL_IRQ];
		st.live_clr = st.last & ~ctrl[CTL_REPEAT];
		cnt_n       = cnt - CNT_W'(1);

		if (st.last) begin
			cnt_n = ctrl[CTL_REPEAT] ? full_count(ctrl[15:0]) : '0;
			if (tmode == AM_RELOAD) begin
				tgt_n = reload_tgt;
			end
		end

		wr_data = {cnt_n, tgt_n, src_n};
	end

endmodule

// ===== hw/rtl/four_channel_dma_sequencer.sv =====
// An accepted input word passes the stage-1 registers and the output register to m_tdata.
// Throughput: one input word per cycle, trigger and advance alike, while m_tready is high.
// The run state sits in a 4-entry RAM; an advance reads its entry in stage 0 and writes
// it back stepped in stage 1, forwarded to an advance on the same channel right behind it.
// arst_n clears config registers, live/armed/forced flags and the pipeline valid bits.
// ----------------------------------------------------------------------------
// four_channel_dma_sequencer
// Four-channel fixed-priority DMA sequencer: arms channels on trigger events
// and issues one transfer unit per advance from the lowest armed channel.
// ----------------------------------------------------------------------------
module four_channel_dma_sequencer #(
	parameter int ADDR_BITS = 28
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [55:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	// vblank_seen, hblank_seen, hdma_seen, fifo_a_level[5:0], fifo_b_level[5:0], pad
	input  logic [15:0] s_tdata,
	// cmd
	input  logic        s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// channel[1:0], source_addr[27:0], target_addr[27:0], word_unit, irq_raise,
	// armed_mask[3:0]
	output logic [63:0] m_tdata,
	// unit_valid
	output logic        m_tuser,
	// last_unit
	output logic        m_tlast
);
	import dsq_pkg::*;

	localparam int RW = 2*ADDR_BITS + CNT_W;

	logic [ADR_W-1:0] addr_q [NUM_CH];
	logic [CTL_W-1:0] ctrl_q [NUM_CH];
	logic [NUM_CH-1:0] live_q, armed_q, forced_q, count4_q;

	logic          valid_s1, cmd_s1, hit_s1, fwd_s1;
	logic [CH_W-1:0] ch_s1;
	logic [RW-1:0] fwd_data_q;

	logic        out_valid_q, out_tuser_q, out_tlast_q;
	logic [63:0] out_tdata_q;

	logic en, acc, act_s1, cfg_ctl;
	logic [CH_W-1:0] cfg_ch, rd_ch;
	logic any_armed;
	logic [NUM_CH-1:0] fin_mask, clr_mask, armed_cur, live_cur, arm_mask, force_mask;
	logic [RW-1:0] rd_data, ram_q, step_wr, ram_wdata;
	logic          ram_we;
	logic [CH_W-1:0] ram_waddr;
	logic [ADDR_BITS-1:0] cur_src, cur_tgt, reload_tgt;
	logic [31:0] src_w, tgt_w;
	step_t st;

	logic vb, hb, hd;
	logic [5:0] lvl_a, lvl_b;

	assign vb    = s_tdata[0];
	assign hb    = s_tdata[1];
	assign hd    = s_tdata[2];
	assign lvl_a = s_tdata[8:3];
	assign lvl_b = s_tdata[14:9];

	assign en       = ~out_valid_q | m_tready;
	assign s_tready = en;
	assign acc      = s_tvalid & en;
	assign cfg_ctl  = cfg_we & (cfg_index >= REG_CTRL0);
	assign cfg_ch   = cfg_index[CH_W-1:0];

	// ---------------- stage 1: step the entry read in stage 0
	assign rd_data    = fwd_s1 ? fwd_data_q : ram_q;
	assign reload_tgt = ADDR_BITS'(addr_q[ch_s1][55:28]);

	dsq_step #(.ADDR_BITS(ADDR_BITS)) u_step (
		.rd_data    (rd_data),
		.count4     (count4_q[ch_s1]),
		.ctrl       (ctrl_q[ch_s1]),
		.forced     (forced_q[ch_s1]),
		.reload_tgt (reload_tgt),
		.cur_src    (cur_src),
		.cur_tgt    (cur_tgt),
		.wr_data    (step_wr),
		.st         (st)
	);

	assign act_s1 = valid_s1 & (cmd_s1 == CMD_ADVANCE) & hit_s1;

	always_comb begin
		fin_mask = '0;
		clr_mask = '0;
		if (act_s1 && st.last) begin
			fin_mask[ch_s1] = 1'b1;
		end
		if (act_s1 && st.live_clr) begin
			clr_mask[ch_s1] = 1'b1;
		end
		armed_cur = armed_q & ~fin_mask;
		live_cur  = live_q & ~clr_mask;
	end

	// ---------------- stage 0: channel select and trigger arming
	always_comb begin
		rd_ch     = '0;
		any_armed = |armed_cur;
		for (int i = NUM_CH-1; i >= 0; i--) begin
			if (armed_cur[i]) begin
				rd_ch = CH_W'(i);
			end
		end
	end

	always_comb begin
		arm_mask   = '0;
		force_mask = '0;
		for (int i = 0; i < NUM_CH; i++) begin
			if (live_cur[i] && !armed_cur[i]) begin
				unique case (ctrl_q[i][CTL_TIM_LO +: 2])
					TIM_NOW:    arm_mask[i] = 1'b1;
					TIM_VBLANK: arm_mask[i] = vb;
					TIM_HBLANK: arm_mask[i] = hb;
					TIM_SPECIAL: begin
						if (i == 1) begin
							force_mask[i] = (lvl_a <= FIFO_THRESHOLD);
						end else if (i == 2) begin
							force_mask[i] = (lvl_b <= FIFO_THRESHOLD);
						end else if (i == 3) begin
							arm_mask[i] = hd;
						end
						arm_mask[i] = arm_mask[i] | force_mask[i];
					end
				endcase
			end
		end
		if (!(acc && s_tuser == CMD_TRIGGER)) begin
			arm_mask   = '0;
			force_mask = '0;
		end
	end

	// ---------------- run state RAM
	always_comb begin
		ram_we    = en & act_s1;
		ram_waddr = ch_s1;
		ram_wdata = step_wr;
		if (cfg_ctl) begin
			ram_we    = 1'b1;
			ram_waddr = cfg_ch;
			ram_wdata = {full_count(cfg_data[15:0]),
				ADDR_BITS'(addr_q[cfg_ch][55:28]),
				ADDR_BITS'(addr_q[cfg_ch][27:0])};
		end
	end

	dsq_ram #(.WIDTH(RW), .DEPTH(NUM_CH)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (en),
		.raddr (rd_ch),
		.rdata (ram_q)
	);

	// ---------------- config registers and channel flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CH; i++) begin
				addr_q[i] <= '0;
				ctrl_q[i] <= '0;
			end
			live_q   <= '0;
			armed_q  <= '0;
			forced_q <= '0;
			count4_q <= '0;
		end else if (cfg_we) begin
			if (cfg_ctl) begin
				ctrl_q[cfg_ch]   <= cfg_data[CTL_W-1:0];
				live_q[cfg_ch]   <= cfg_data[CTL_EN];
				armed_q[cfg_ch]  <= 1'b0;
				forced_q[cfg_ch] <= 1'b0;
				count4_q[cfg_ch] <= 1'b0;
			end else begin
				addr_q[cfg_ch] <= cfg_data;
			end
		end else if (en) begin
			live_q   <= live_cur;
			armed_q  <= armed_cur | arm_mask;
			forced_q <= forced_q | force_mask;
			count4_q <= (count4_q & ~(act_s1 ? (NUM_CH'(1) << ch_s1) : '0)) | force_mask;
		end
	end

	// ---------------- pipeline and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			fwd_s1      <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			valid_s1    <= acc;
			fwd_s1      <= act_s1 & (ch_s1 == rd_ch);
			out_valid_q <= valid_s1;
		end
	end

	assign src_w = 32'(cur_src);
	assign tgt_w = 32'(cur_tgt);

	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s1     <= s_tuser;
			hit_s1     <= any_armed;
			ch_s1      <= rd_ch;
			fwd_data_q <= step_wr;
			if (act_s1) begin
				out_tdata_q <= {armed_cur, st.irq, st.word, tgt_w[OUT_AW-1:0],
					src_w[OUT_AW-1:0], ch_s1};
			end else begin
				out_tdata_q <= {armed_cur, 60'd0};
			end
			out_tuser_q <= act_s1;
			out_tlast_q <= act_s1 & st.last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_tdata_q;
	assign m_tuser  = out_tuser_q;
	assign m_tlast  = out_tlast_q;

	// ---------------- checks
	a_armed_live: assert property (@(posedge clk) disable iff (!arst_n)
		(armed_q & ~live_q) == '0)
		else $error("armed channel not live");

	a_count4_forced: assert property (@(posedge clk) disable iff (!arst_n)
		(count4_q & ~forced_q) == '0)
		else $error("count override without fifo mode");

	a_forced_chan: assert property (@(posedge clk) disable iff (!arst_n)
		!forced_q[0] && !forced_q[3])
		else $error("fifo mode on channel 0 or 3");

	a_fwd_advance: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(fwd_s1) |-> $past(act_s1))
		else $error("forward without a write-back");

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for four_channel_dma_sequencer. Trigger and advance
// words stream in, a local model of channel arming, priority and address
// stepping predicts every output word, and the monitor compares them in order
// across several register settings, idle patterns and a long output stall.
// ----------------------------------------------------------------------------
module tb;
	import dsq_pkg::*;

	localparam logic [2:0] REG_ADDR0 = 3'd0;

	typedef struct packed {
		logic       cmd;
		logic       vb;
		logic       hb;
		logic       hd;
		logic [5:0] fa;
		logic [5:0] fb;
	} dma_req_t;

	typedef struct packed {
		logic        uv;
		logic [1:0]  ch;
		logic [27:0] src;
		logic [27:0] tgt;
		logic        word;
		logic        last;
		logic        irq;
		logic [3:0]  mask;
	} unit_rec_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [55:0] cfg_data = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;
	logic        s_tuser = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [63:0] m_tdata;
	logic        m_tuser;
	logic        m_tlast;

	dma_req_t  req_q[$];
	unit_rec_t unit_q[$];
	dma_req_t  cur_req;
	unit_rec_t exp_u, act_u;
	int        send_idle = 20;
	int        recv_stall = 69;
	int        fail_cnt = 0;
	int        mism_cnt = 0;
	logic      hold_go = 1'b0;
	logic      hold_on = 1'b0;

	// channel model
	logic [55:0] addr_r [NUM_CH];
	logic [25:0] ctl_r [NUM_CH];
	logic [27:0] src_r [NUM_CH];
	logic [27:0] tgt_r [NUM_CH];
	logic [16:0] cnt_r [NUM_CH];
	logic [3:0]  live_r = '0;
	logic [3:0]  forced_r = '0;
	logic [3:0]  armed_r = '0;

	four_channel_dma_sequencer i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("status: fail");
		$finish;
	end

	function automatic unit_rec_t issue_unit(input dma_req_t r);
		unit_rec_t  u;
		logic [1:0] tim, sm, dm;
		logic [5:0] lvl;
		logic [2:0] seek;
		logic       fz, hit;
		int         ch, sel;
		u = '0;
		if (r.cmd == CMD_TRIGGER) begin
			for (ch = 0; ch < NUM_CH; ch++) begin
				tim = ctl_r[ch][CTL_TIM_LO +: 2];
				hit = 1'b0;
				if (live_r[ch] && !armed_r[ch]) begin
					case (tim)
						TIM_NOW:    hit = 1'b1;
						TIM_VBLANK: hit = r.vb;
						TIM_HBLANK: hit = r.hb;
						default: begin
							if (ch == 3) begin
								hit = r.hd;
							end else if (ch != 0) begin
								lvl = (ch == 1) ? r.fa : r.fb;
								if (lvl <= FIFO_THRESHOLD) begin
									hit = 1'b1;
									forced_r[ch] = 1'b1;
									cnt_r[ch] = FORCED_COUNT;
								end
							end
						end
					endcase
				end
				if (hit)
					armed_r[ch] = 1'b1;
			end
		end else begin
			sel = -1;
			for (ch = NUM_CH - 1; ch >= 0; ch--)
				if (armed_r[ch])
					sel = ch;
			if (sel >= 0) begin
				fz = forced_r[sel];
				u.uv = 1'b1;
				u.ch = sel[1:0];
				u.src = src_r[sel];
				u.tgt = tgt_r[sel];
				u.word = fz | ctl_r[sel][CTL_WORD];
				seek = u.word ? 3'd4 : 3'd2;
				sm = ctl_r[sel][CTL_SRC_LO +: 2];
				dm = fz ? AM_FIXED : ctl_r[sel][CTL_DST_LO +: 2];
				if (sm == AM_INC)
					src_r[sel] = src_r[sel] + seek;
				else if (sm == AM_DEC)
					src_r[sel] = src_r[sel] - seek;
				if (dm == AM_INC || dm == AM_RELOAD)
					tgt_r[sel] = tgt_r[sel] + seek;
				else if (dm == AM_DEC)
					tgt_r[sel] = tgt_r[sel] - seek;
				u.last = (cnt_r[sel] <= 17'd1);
				cnt_r[sel] = u.last ? '0 : cnt_r[sel] - 17'd1;
				if (u.last) begin
					if (dm == AM_RELOAD)
						tgt_r[sel] = addr_r[sel][55:28];
					if (ctl_r[sel][CTL_REPEAT])
						cnt_r[sel] = {ctl_r[sel][15:0] == 16'd0, ctl_r[sel][15:0]};
					else
						live_r[sel] = 1'b0;
					armed_r[sel] = 1'b0;
					u.irq = ctl_r[sel][CTL_IRQ];
				end
			end
		end
		u.mask = armed_r;
		return u;
	endfunction

	// driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				unit_q.push_back(issue_unit(cur_req));
			if (!s_tvalid || s_tready) begin
				if (req_q.size() != 0 && $urandom_range(99) >= send_idle) begin
					cur_req = req_q.pop_front();
					s_tvalid <= 1'b1;
					s_tuser <= cur_req.cmd;
					s_tdata <= {1'b0, cur_req.fb, cur_req.fa, cur_req.hd, cur_req.hb,
						cur_req.vb};
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n) begin
			m_tready <= !hold_on && ($urandom_range(99) >= recv_stall);
			if (m_tvalid && m_tready) begin
				act_u.uv = m_tuser;
				act_u.ch = m_tdata[1:0];
				act_u.src = m_tdata[29:2];
				act_u.tgt = m_tdata[57:30];
				act_u.word = m_tdata[58];
				act_u.irq = m_tdata[59];
				act_u.mask = m_tdata[63:60];
				act_u.last = m_tlast;
				if (unit_q.size() == 0) begin
					fail_cnt++;
					mism_cnt++;
					if (mism_cnt <= 10)
						$display("unexpected word: %h user=%b last=%b", m_tdata, m_tuser,
							m_tlast);
				end else begin
					exp_u = unit_q.pop_front();
					if (act_u !== exp_u) begin
						fail_cnt++;
						mism_cnt++;
						if (mism_cnt <= 10) begin
							$display("mismatch exp: uv=%b ch=%0d src=%h tgt=%h w=%b last=%b irq=%b mask=%h",
								exp_u.uv, exp_u.ch, exp_u.src, exp_u.tgt, exp_u.word,
								exp_u.last, exp_u.irq, exp_u.mask);
							$display("         got: uv=%b ch=%0d src=%h tgt=%h w=%b last=%b irq=%b mask=%h",
								act_u.uv, act_u.ch, act_u.src, act_u.tgt, act_u.word,
								act_u.last, act_u.irq, act_u.mask);
						end
					end
				end
			end
		end
	end

	// long output stall
	initial begin
		wait (hold_go);
		@(posedge clk);
		hold_on <= 1'b1;
		repeat (300) @(posedge clk);
		hold_on <= 1'b0;
	end

	task automatic write_reg(input int idx, input logic [55:0] val);
		int ch;
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= 3'(idx);
		cfg_data <= val;
		ch = idx % NUM_CH;
		if (idx < int'(REG_CTRL0)) begin
			addr_r[ch] = val;
		end else begin
			ctl_r[ch] = val[CTL_W-1:0];
			src_r[ch] = addr_r[ch][27:0];
			tgt_r[ch] = addr_r[ch][55:28];
			cnt_r[ch] = {ctl_r[ch][15:0] == 16'd0, ctl_r[ch][15:0]};
			live_r[ch] = ctl_r[ch][CTL_EN];
			forced_r[ch] = 1'b0;
			armed_r[ch] = 1'b0;
		end
	endtask

	task automatic end_writes();
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic drain();
		while (req_q.size() != 0 || s_tvalid || unit_q.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic queue_req(input logic cmd, input int vb, input int hb, input int hd,
		input logic [5:0] fa, input logic [5:0] fb);
		dma_req_t r;
		r.cmd = cmd;
		r.vb = vb[0];
		r.hb = hb[0];
		r.hd = hd[0];
		r.fa = fa;
		r.fb = fb;
		req_q.push_back(r);
	endtask

	function automatic logic [55:0] ctl_word(input logic [15:0] cnt, input logic en,
		input logic [1:0] tim, input logic [1:0] sm, input logic [1:0] dm, input int w,
		input int rep, input int irq);
		return 56'({irq[0], rep[0], w[0], dm, sm, tim, en, cnt});
	endfunction

	function automatic logic [27:0] rand_addr();
		case ($urandom_range(5))
			0: return 28'h0;
			1: return 28'hFFFFFFF;
			2: return 28'($urandom_range(1, 6));
			3: return 28'hFFFFFFF - 28'($urandom_range(0, 6));
			default: return 28'($urandom);
		endcase
	endfunction

	function automatic logic [55:0] rand_ctl();
		logic [25:0] v;
		v = 26'($urandom);
		case ($urandom_range(9))
			0: v[15:0] = 16'd0;
			1: v[15:0] = 16'hFFFF;
			2: v[15:0] = 16'($urandom);
			default: v[15:0] = 16'($urandom_range(1, 6));
		endcase
		v[CTL_EN] = ($urandom_range(7) != 0);
		return 56'(v);
	endfunction

	task automatic config_random();
		int ch;
		for (ch = 0; ch < NUM_CH; ch++)
			write_reg(int'(REG_ADDR0) + ch, {rand_addr(), rand_addr()});
		for (ch = 0; ch < NUM_CH; ch++)
			write_reg(int'(REG_CTRL0) + ch, rand_ctl());
		for (ch = 0; ch < NUM_CH; ch++)
			if ($urandom_range(1))
				write_reg(int'(REG_ADDR0) + ch, {rand_addr(), rand_addr()});
		end_writes();
	endtask

	task automatic run_random(input int n, input bit with_hold);
		dma_req_t r;
		int k;
		for (k = 0; k < n; k++) begin
			r.cmd = ($urandom_range(99) < 60) ? CMD_ADVANCE : CMD_TRIGGER;
			r.vb = 1'($urandom_range(1));
			r.hb = 1'($urandom_range(1));
			r.hd = 1'($urandom_range(1));
			r.fa = ($urandom_range(3) == 0) ? 6'($urandom_range(63)) :
				6'($urandom_range(12, 20));
			r.fb = ($urandom_range(3) == 0) ? 6'($urandom_range(63)) :
				6'($urandom_range(12, 20));
			req_q.push_back(r);
		end
		if (with_hold)
			hold_go = 1'b1;
		drain();
	endtask

	initial begin
		int ph, ch;
		for (ch = 0; ch < NUM_CH; ch++) begin
			addr_r[ch] = '0;
			ctl_r[ch] = '0;
			src_r[ch] = '0;
			tgt_r[ch] = '0;
			cnt_r[ch] = '0;
		end
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// directed: priority, arming rules, forced audio channels, wrap, reload
		write_reg(REG_ADDR0 + 0, {28'hFFFFFF0, 28'h0000000});
		write_reg(REG_ADDR0 + 1, {28'h0000100, 28'hFFFFFFE});
		write_reg(REG_ADDR0 + 2, {28'h0000002, 28'h1234567});
		write_reg(REG_ADDR0 + 3, {28'hABCDEF0, 28'h7FFFFFF});
		write_reg(REG_CTRL0 + 0, ctl_word(16'd1, 1'b1, TIM_NOW, AM_DEC, AM_RELOAD, 0, 0, 1));
		write_reg(REG_CTRL0 + 1, ctl_word(16'd2, 1'b1, TIM_SPECIAL, AM_INC, AM_INC, 0, 1, 0));
		write_reg(REG_CTRL0 + 2, ctl_word(16'd0, 1'b1, TIM_VBLANK, AM_RELOAD, AM_DEC, 1, 0, 0));
		write_reg(REG_CTRL0 + 3, ctl_word(16'd3, 1'b1, TIM_SPECIAL, AM_FIXED, AM_FIXED, 0, 1, 1));
		end_writes();
		queue_req(CMD_ADVANCE, 0, 0, 0, 6'd0, 6'd0);
		queue_req(CMD_TRIGGER, 0, 0, 0, 6'd17, 6'd63);
		queue_req(CMD_ADVANCE, 1, 1, 1, 6'd63, 6'd63);
		queue_req(CMD_ADVANCE, 0, 0, 0, 6'd0, 6'd0);
		queue_req(CMD_TRIGGER, 1, 1, 1, 6'd16, 6'd0);
		queue_req(CMD_TRIGGER, 1, 1, 1, 6'd0, 6'd0);
		repeat (4) queue_req(CMD_ADVANCE, 0, 0, 0, 6'd0, 6'd0);
		queue_req(CMD_TRIGGER, 0, 1, 0, 6'd63, 6'd32);
		repeat (2) queue_req(CMD_ADVANCE, 0, 0, 0, 6'd0, 6'd0);
		drain();
		write_reg(REG_CTRL0 + 2, ctl_word(16'd1, 1'b1, TIM_HBLANK, AM_INC, AM_RELOAD, 0, 0, 1));
		end_writes();
		repeat (4) queue_req(CMD_ADVANCE, 0, 0, 0, 6'd0, 6'd0);
		queue_req(CMD_TRIGGER, 0, 1, 0, 6'd63, 6'd63);
		queue_req(CMD_ADVANCE, 0, 0, 0, 6'd0, 6'd0);
		queue_req(CMD_TRIGGER, 0, 0, 1, 6'd32, 6'd16);
		queue_req(CMD_ADVANCE, 0, 0, 0, 6'd0, 6'd0);
		drain();

		// all registers cleared
		for (ch = 0; ch < 2 * NUM_CH; ch++)
			write_reg(ch, '0);
		end_writes();
		run_random(40, 1'b0);

		// all registers set
		for (ch = 0; ch < 2 * NUM_CH; ch++)
			write_reg(ch, {ADR_W{1'b1}});
		end_writes();
		run_random(120, 1'b0);

		for (ph = 3; ph < 12; ph++) begin
			if (ph == 4) begin
				send_idle = 69;
				recv_stall = 20;
			end else if (ph == 8) begin
				send_idle = 0;
				recv_stall = 0;
			end
			config_random();
			run_random(120, ph == 9);
		end

		repeat (6) @(negedge clk);
		fail_cnt += unit_q.size();
		if (fail_cnt == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/dsq_pkg.sv
hw/rtl/dsq_ram.sv
hw/rtl/dsq_step.sv
hw/rtl/four_channel_dma_sequencer.sv
sim/tb.sv
